// ----- rtl/cht_pkg.sv -----
// ---------------------------------------------------------------------------
// cht_pkg
// Shared types and codes for the chained hash table.
// ---------------------------------------------------------------------------
package cht_pkg;

    // Request operations
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // Response status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_GOT,
        S_WALK,
        S_CMP,
        S_ALLOC_GOT,
        S_INS_WR,
        S_DEL_UNLINK,
        S_DEL_FREE
    } state_t;

endpackage

// ----- rtl/cht_if.sv -----
// ---------------------------------------------------------------------------
// cht_req_if / cht_rsp_if
// Valid/ready channels for requests and responses.
// ---------------------------------------------------------------------------
interface cht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] lookup_key;
    logic [31:0] entry_value;

    modport source  (output valid, cmd, lookup_key, entry_value, input ready);
    modport sink    (input valid, cmd, lookup_key, entry_value, output ready);
    modport monitor (input valid, ready, cmd, lookup_key, entry_value);
endinterface

interface cht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] value_out;

    modport source  (output valid, status, value_out, input ready);
    modport sink    (input valid, status, value_out, output ready);
    modport monitor (input valid, ready, status, value_out);
endinterface

// ----- rtl/cht_bucket_mod.sv -----
// ---------------------------------------------------------------------------
// cht_bucket_mod
// Bucket index = key mod BUCKETS. Power-of-two counts take the low bits
// directly; other counts use a round-up reciprocal multiply.
// ---------------------------------------------------------------------------
module cht_bucket_mod
    import cht_pkg::*;
#(
    parameter int BUCKETS = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);
    localparam int  BW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = ((1 << BW) == BUCKETS);
    localparam int  SH      = 32 + BW;
    // ceil(2^SH / BUCKETS): below 2^33 for any non power-of-two count
    localparam logic [63:0] RECIP    = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1)
                                       / 64'(BUCKETS);
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];
    localparam logic [16:0] DIVISOR  = 17'(BUCKETS);

    logic [2:0]    stage_reg, stage_next;
    logic          done_reg, done_next;
    logic [31:0]   key_reg, key_next;
    logic [47:0]   plo_reg, plo_next;
    logic [48:0]   phi_reg, phi_next;
    logic [31:0]   quo_reg, quo_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [64:0]   prod;
    logic [48:0]   back;
    logic [31:0]   diff;

    // partial products, quotient, remainder; one step per cycle
    always_comb
    begin
        stage_next = {stage_reg[1:0], 1'b0};
        done_next  = stage_reg[2];
        key_next   = key_reg;
        plo_next   = key_reg * RECIP_LO;
        phi_next   = key_reg * RECIP_HI;
        prod       = {phi_reg, 16'd0} + 65'(plo_reg);
        quo_next   = 32'(prod >> SH);
        back       = quo_reg * DIVISOR;
        diff       = key_reg - back[31:0];
        rem_next   = rem_reg;
        if (stage_reg[2])
        begin
            rem_next = diff[BW-1:0];
        end
        if (start)
        begin
            if (IS_POW2)
            begin
                rem_next  = key[BW-1:0];
                done_next = 1'b1;
            end
            else
            begin
                key_next   = key;
                stage_next = 3'b001;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

// ----- rtl/chained_hash_table_top.sv -----
// ---------------------------------------------------------------------------
// chained_hash_table_top
// Key/value table with separate chaining over a fixed node pool.
// ---------------------------------------------------------------------------
// One request at a time. After reset the block sweeps the bucket-head memory,
// one bucket per cycle, before it takes its first word. A request then passes
// S_MOD, S_HEAD_RD and S_HEAD_GOT to reach its bucket head, and S_WALK and
// S_CMP per chain node visited (one node memory read and one key compare per
// node); an empty chain goes straight to S_CMP. Insert adds S_INS_WR, plus
// S_ALLOC_GOT for a reused freed node; delete adds S_DEL_UNLINK, S_DEL_FREE.
// A non power-of-two BUCKETS holds S_MOD longer for the reciprocal remainder.
// The response sits in an output register; the next request is taken the
// cycle after it has been taken, so chain length sets the rate.
// ---------------------------------------------------------------------------
module chained_hash_table_top
    import cht_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int POOL_NODES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    cht_req_if.sink    req,
    cht_rsp_if.source  rsp
);
    localparam int BW = $clog2(BUCKETS);
    localparam int AW = $clog2(POOL_NODES);
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    // memories
    logic [NW-1:0] head_mem [BUCKETS];
    logic [31:0]   key_mem  [POOL_NODES];
    logic [31:0]   val_mem  [POOL_NODES];
    logic [NW-1:0] link_mem [POOL_NODES];

    logic [NW-1:0] head_q;
    logic [31:0]   key_q, val_q;
    logic [NW-1:0] link_q;

    state_t        state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] prev_reg, prev_next;
    logic [NW-1:0] headv_reg, headv_next;
    logic [NW-1:0] nxt_reg, nxt_next;
    logic [NW-1:0] free_reg, free_next;
    logic [NW-1:0] used_reg, used_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   value_reg, value_next;

    logic          mod_start, mod_done;
    logic [BW-1:0] bucket;

    logic          head_we;
    logic [BW-1:0] head_waddr;
    logic [NW-1:0] head_wdata;
    logic [NW-1:0] node_raddr;
    logic          kv_we;
    logic          link_we;
    logic [NW-1:0] link_waddr;
    logic [NW-1:0] link_wdata;

    cht_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key    (key_next),
        .done   (mod_done),
        .bucket (bucket)
    );

    // bucket-head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[bucket];
    end

    // node memories
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            key_mem[cur_reg[AW-1:0]] <= key_reg;
            val_mem[cur_reg[AW-1:0]] <= val_reg;
        end
        if (link_we)
        begin
            link_mem[link_waddr[AW-1:0]] <= link_wdata;
        end
        key_q  <= key_mem[node_raddr[AW-1:0]];
        val_q  <= val_mem[node_raddr[AW-1:0]];
        link_q <= link_mem[node_raddr[AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        headv_next  = headv_reg;
        nxt_next    = nxt_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        value_next  = value_reg;
        mod_start   = 1'b0;
        head_we     = 1'b0;
        head_waddr  = bucket;
        head_wdata  = cur_reg;
        node_raddr  = cur_reg;
        kv_we       = 1'b0;
        link_we     = 1'b0;
        link_waddr  = cur_reg;
        link_wdata  = headv_reg;
        req.ready   = 1'b0;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NIL;
                clr_next   = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = !ovalid_reg;
                if (req.valid && !ovalid_reg)
                begin
                    cmd_next = req.cmd;
                    key_next = req.lookup_key;
                    val_next = req.entry_value;
                    if (req.cmd == CMD_INSERT || req.cmd == CMD_SEARCH ||
                        req.cmd == CMD_DELETE)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        status_next = ST_DONE;
                        value_next  = '0;
                    end
                end
            end
            S_MOD:
            begin
                // bucket calculation launched on accept; wait for the index
                if (mod_done)
                begin
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_GOT;
            end
            S_HEAD_GOT:
            begin
                headv_next = head_q;
                cur_next   = head_q;
                prev_next  = NIL;
                if (head_q == NIL)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cur_reg != NIL && key_q == key_reg)
                begin
                    // hit
                    value_next  = '0;
                    status_next = ST_DONE;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        status_next = ST_DUP;
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (cmd_reg == CMD_SEARCH)
                    begin
                        value_next  = val_q;
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        value_next = val_q;
                        nxt_next   = link_q;
                        state_next = S_DEL_UNLINK;
                    end
                end
                else if (cur_reg != NIL && link_q != NIL)
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_q;
                    state_next = S_WALK;
                end
                else
                begin
                    // miss
                    value_next = '0;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (free_reg != NIL)
                        begin
                            // fetch the link of the free-list head
                            node_raddr = free_reg;
                            cur_next   = free_reg;
                            state_next = S_ALLOC_GOT;
                        end
                        else if (used_reg != NIL)
                        begin
                            cur_next   = used_reg;
                            used_next  = used_reg + NW'(1);
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            ovalid_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_ALLOC_GOT:
            begin
                // link of the reused node was read last cycle
                free_next  = link_q;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                kv_we       = 1'b1;
                link_we     = 1'b1;
                link_waddr  = cur_reg;
                link_wdata  = headv_reg;
                head_we     = 1'b1;
                head_wdata  = cur_reg;
                status_next = ST_DONE;
                value_next  = '0;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_DEL_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = nxt_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg;
                    link_wdata = nxt_reg;
                end
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                link_we     = 1'b1;
                link_waddr  = cur_reg;
                link_wdata  = free_reg;
                free_next   = cur_reg;
                status_next = ST_DONE;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch the bucket calculation as the request is taken
        mod_start = (state_reg == S_IDLE) && (state_next == S_MOD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            free_reg   <= NIL;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        headv_reg  <= headv_next;
        nxt_reg    <= nxt_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_reg;

endmodule
